// ===== rtl/core/joystick_direction_repeat_macros.svh =====
// ----------------------------------------------------------------------------
// joystick_direction_repeat_macros
// assertion macros used by the joystick direction repeat checker
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_DIRECTION_REPEAT_MACROS_SVH
`define JOYSTICK_DIRECTION_REPEAT_MACROS_SVH

// property checked only outside reset
`define JDR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also covers the reset cycles
`define JDR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/jdr_pkg.sv =====
// ----------------------------------------------------------------------------
// jdr_pkg
// shared types and constants of the joystick direction repeat block
// ----------------------------------------------------------------------------
package jdr_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int TIME_BITS   = 16;
  localparam int TIMER_BITS  = 32;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  // register defaults; all but the centre are also used when their register holds zero
  localparam logic [SAMPLE_BITS-1:0] CENTER_RESET     = SAMPLE_BITS'(2048);
  localparam logic [SAMPLE_BITS-1:0] ACTIVATION_DFLT  = SAMPLE_BITS'(900);
  localparam logic [SAMPLE_BITS-1:0] RELEASE_DFLT     = SAMPLE_BITS'(500);
  localparam logic [TIME_BITS-1:0]   REPEAT_DELAY_DFLT = TIME_BITS'(350);
  localparam logic [TIME_BITS-1:0]   REPEAT_INTVL_DFLT = TIME_BITS'(140);

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_LEFT  = 3'd1,
    DIR_RIGHT = 3'd2,
    DIR_DOWN  = 3'd3,
    DIR_UP    = 3'd4
  } dir_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CENTER_X   = 3'd0,
    CFG_CENTER_Y   = 3'd1,
    CFG_ACTIVATION = 3'd2,
    CFG_RELEASE    = 3'd3,
    CFG_DELAY      = 3'd4,
    CFG_INTERVAL   = 3'd5
  } cfg_reg_t;

  // classifier result: winning direction plus the two threshold tests
  typedef struct packed {
    dir_t dir;
    logic below_act;
    logic below_rel;
  } cls_t;

endpackage

// ===== rtl/core/jdr_classify.sv =====
// ----------------------------------------------------------------------------
// jdr_classify
// offset from centre, axis pick and threshold tests for one sample
// ----------------------------------------------------------------------------
module jdr_classify (
  input  logic [jdr_pkg::SAMPLE_BITS-1:0] sample_x,
  input  logic [jdr_pkg::SAMPLE_BITS-1:0] sample_y,
  input  logic [jdr_pkg::SAMPLE_BITS-1:0] rest_x,
  input  logic [jdr_pkg::SAMPLE_BITS-1:0] rest_y,
  input  logic [jdr_pkg::SAMPLE_BITS-1:0] act_thr,
  input  logic [jdr_pkg::SAMPLE_BITS-1:0] rel_thr,
  output jdr_pkg::cls_t                   cls
);

  logic signed [jdr_pkg::SAMPLE_BITS:0] dx;
  logic signed [jdr_pkg::SAMPLE_BITS:0] dy;
  logic [jdr_pkg::SAMPLE_BITS-1:0]      ax;
  logic [jdr_pkg::SAMPLE_BITS-1:0]      ay;
  logic [jdr_pkg::SAMPLE_BITS:0]        neg_dx;
  logic [jdr_pkg::SAMPLE_BITS:0]        neg_dy;

  assign dx = $signed({1'b0, sample_x}) - $signed({1'b0, rest_x});
  assign dy = $signed({1'b0, sample_y}) - $signed({1'b0, rest_y});

  assign neg_dx = -dx;
  assign neg_dy = -dy;

  // magnitudes fit in SAMPLE_BITS bits
  assign ax = dx[jdr_pkg::SAMPLE_BITS] ? neg_dx[jdr_pkg::SAMPLE_BITS-1:0]
                                       : dx[jdr_pkg::SAMPLE_BITS-1:0];
  assign ay = dy[jdr_pkg::SAMPLE_BITS] ? neg_dy[jdr_pkg::SAMPLE_BITS-1:0]
                                       : dy[jdr_pkg::SAMPLE_BITS-1:0];

  always_comb begin
    // ties go to the horizontal axis
    if (ax >= ay) begin
      cls.dir = dx[jdr_pkg::SAMPLE_BITS] ? jdr_pkg::DIR_LEFT : jdr_pkg::DIR_RIGHT;
    end else begin
      cls.dir = dy[jdr_pkg::SAMPLE_BITS] ? jdr_pkg::DIR_DOWN : jdr_pkg::DIR_UP;
    end
    cls.below_act = (ax < act_thr) && (ay < act_thr);
    cls.below_rel = (ax < rel_thr) && (ay < rel_thr);
  end

endmodule

// ===== rtl/core/joystick_direction_repeat.sv =====
// ----------------------------------------------------------------------------
// joystick_direction_repeat
// four-direction joystick decoder with hysteresis and held-direction repeat
// ----------------------------------------------------------------------------
// Each input word carries one x/y ADC sample and the milliseconds since the
// previous sample; each one yields exactly one output word holding a
// direction event (0 none, 1 left, 2 right, 3 down, 4 up). The larger axis
// offset from the configured centre wins, ties go to horizontal. Entering a
// direction needs the activation threshold, staying needs the release
// threshold, a switch needs activation again. A held direction is emitted on
// entry, after the repeat delay and then every repeat interval; the timers
// are 32-bit and saturate. A word with zero elapsed time gives event 0 and
// leaves the state alone. Zero in a threshold or timing register selects its
// default; a release value at or above activation becomes activation / 2.
// Words pass the input and result registers; one word can be taken every
// cycle unless the output stalls: the only loop is the held-direction
// state, updated in a single pass per word. Write the configuration only
// while no word is in flight; writes to indexes 6 and 7 are dropped.
module joystick_direction_repeat (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [jdr_pkg::SAMPLE_BITS-1:0]  in_sample_x,
  input  logic [jdr_pkg::SAMPLE_BITS-1:0]  in_sample_y,
  input  logic [jdr_pkg::TIME_BITS-1:0]    in_elapsed_time,

  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_direction_event,

  input  logic                             cfg_write_en,
  input  logic [jdr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [jdr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [jdr_pkg::TIMER_BITS-1:0] TIMER_MAX = '1;

  // configuration registers
  logic [jdr_pkg::SAMPLE_BITS-1:0] rest_x_r;
  logic [jdr_pkg::SAMPLE_BITS-1:0] rest_y_r;
  logic [jdr_pkg::SAMPLE_BITS-1:0] activation_r;
  logic [jdr_pkg::SAMPLE_BITS-1:0] release_r;
  logic [jdr_pkg::TIME_BITS-1:0]   delay_r;
  logic [jdr_pkg::TIME_BITS-1:0]   interval_r;

  // input stage
  logic                            s1_valid_r;
  logic [jdr_pkg::SAMPLE_BITS-1:0] s1_x_r;
  logic [jdr_pkg::SAMPLE_BITS-1:0] s1_y_r;
  logic [jdr_pkg::TIME_BITS-1:0]   s1_elapsed_r;

  // held-direction state
  jdr_pkg::dir_t                   held_dir_r,  held_dir_nxt;
  logic [jdr_pkg::TIMER_BITS-1:0]  held_time_r, held_time_nxt;
  logic [jdr_pkg::TIMER_BITS-1:0]  next_rep_r,  next_rep_nxt;

  // result stage
  logic                            out_valid_r;
  jdr_pkg::dir_t                   out_dir_r,   out_dir_nxt;

  logic advance;
  logic s1_fire;

  logic [jdr_pkg::SAMPLE_BITS-1:0] eff_act;
  logic [jdr_pkg::SAMPLE_BITS-1:0] rel_pick;
  logic [jdr_pkg::SAMPLE_BITS-1:0] eff_rel;
  logic [jdr_pkg::TIME_BITS-1:0]   eff_delay;
  logic [jdr_pkg::TIME_BITS-1:0]   eff_interval;

  logic [jdr_pkg::TIMER_BITS:0]    held_sum;
  logic [jdr_pkg::TIMER_BITS-1:0]  held_sat;
  logic [jdr_pkg::TIMER_BITS:0]    rep_sum;
  logic [jdr_pkg::TIMER_BITS-1:0]  rep_sat;

  jdr_pkg::cls_t                   cls;

  // result register drains or is empty: the input stage may move on
  assign advance  = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  assign out_valid           = out_valid_r;
  assign out_direction_event = out_dir_r;

  // effective settings, zero picks the default
  assign eff_act      = (activation_r != '0) ? activation_r : jdr_pkg::ACTIVATION_DFLT;
  assign rel_pick     = (release_r != '0) ? release_r : jdr_pkg::RELEASE_DFLT;
  assign eff_rel      = (rel_pick >= eff_act) ? (eff_act >> 1) : rel_pick;
  assign eff_delay    = (delay_r != '0) ? delay_r : jdr_pkg::REPEAT_DELAY_DFLT;
  assign eff_interval = (interval_r != '0) ? interval_r : jdr_pkg::REPEAT_INTVL_DFLT;

  jdr_classify u_classify (
    .sample_x (s1_x_r),
    .sample_y (s1_y_r),
    .rest_x   (rest_x_r),
    .rest_y   (rest_y_r),
    .act_thr  (eff_act),
    .rel_thr  (eff_rel),
    .cls      (cls)
  );

  // saturating timer adds
  assign held_sum = {1'b0, held_time_r}
                  + {{(jdr_pkg::TIMER_BITS - jdr_pkg::TIME_BITS + 1){1'b0}}, s1_elapsed_r};
  assign held_sat = held_sum[jdr_pkg::TIMER_BITS] ? TIMER_MAX
                                                  : held_sum[jdr_pkg::TIMER_BITS-1:0];
  assign rep_sum  = {1'b0, next_rep_r}
                  + {{(jdr_pkg::TIMER_BITS - jdr_pkg::TIME_BITS + 1){1'b0}}, eff_interval};
  assign rep_sat  = rep_sum[jdr_pkg::TIMER_BITS] ? TIMER_MAX
                                                 : rep_sum[jdr_pkg::TIMER_BITS-1:0];

  // one pass of the hysteresis / repeat decision
  always_comb begin
    held_dir_nxt  = held_dir_r;
    held_time_nxt = held_time_r;
    next_rep_nxt  = next_rep_r;
    out_dir_nxt   = jdr_pkg::DIR_NONE;

    if (s1_elapsed_r != '0) begin
      if (held_dir_r == jdr_pkg::DIR_NONE) begin
        // idle: enter on activation
        if (!cls.below_act) begin
          held_dir_nxt  = cls.dir;
          held_time_nxt = '0;
          next_rep_nxt  = {{(jdr_pkg::TIMER_BITS - jdr_pkg::TIME_BITS){1'b0}}, eff_delay};
          out_dir_nxt   = cls.dir;
        end
      end else if (cls.below_rel) begin
        // back inside the release window
        held_dir_nxt  = jdr_pkg::DIR_NONE;
        held_time_nxt = '0;
        next_rep_nxt  = '0;
      end else if ((cls.dir != held_dir_r) && !cls.below_act) begin
        // switch to another direction, full activation met
        held_dir_nxt  = cls.dir;
        held_time_nxt = '0;
        next_rep_nxt  = {{(jdr_pkg::TIMER_BITS - jdr_pkg::TIME_BITS){1'b0}}, eff_delay};
        out_dir_nxt   = cls.dir;
      end else begin
        // still held: run the repeat timer
        held_time_nxt = held_sat;
        if (held_sat >= next_rep_r) begin
          next_rep_nxt = rep_sat;
          out_dir_nxt  = held_dir_r;
        end
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_x_r     <= jdr_pkg::CENTER_RESET;
      rest_y_r     <= jdr_pkg::CENTER_RESET;
      activation_r <= jdr_pkg::ACTIVATION_DFLT;
      release_r    <= jdr_pkg::RELEASE_DFLT;
      delay_r      <= jdr_pkg::REPEAT_DELAY_DFLT;
      interval_r   <= jdr_pkg::REPEAT_INTVL_DFLT;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        jdr_pkg::CFG_CENTER_X:   rest_x_r     <= cfg_data[jdr_pkg::SAMPLE_BITS-1:0];
        jdr_pkg::CFG_CENTER_Y:   rest_y_r     <= cfg_data[jdr_pkg::SAMPLE_BITS-1:0];
        jdr_pkg::CFG_ACTIVATION: activation_r <= cfg_data[jdr_pkg::SAMPLE_BITS-1:0];
        jdr_pkg::CFG_RELEASE:    release_r    <= cfg_data[jdr_pkg::SAMPLE_BITS-1:0];
        jdr_pkg::CFG_DELAY:      delay_r      <= cfg_data[jdr_pkg::TIME_BITS-1:0];
        jdr_pkg::CFG_INTERVAL:   interval_r   <= cfg_data[jdr_pkg::TIME_BITS-1:0];
        default: begin
          // unused index, dropped
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x_r       <= in_sample_x;
      s1_y_r       <= in_sample_y;
      s1_elapsed_r <= in_elapsed_time;
    end
  end

  // state and result register, updated as a word leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_dir_r  <= jdr_pkg::DIR_NONE;
      held_time_r <= '0;
      next_rep_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        held_dir_r  <= held_dir_nxt;
        held_time_r <= held_time_nxt;
        next_rep_r  <= next_rep_nxt;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_dir_r <= out_dir_nxt;
    end
  end

endmodule

// ===== rtl/core/jdr_checker.sv =====
// ----------------------------------------------------------------------------
// jdr_checker
// port-level checks of the joystick direction repeat block
// ----------------------------------------------------------------------------
`include "joystick_direction_repeat_macros.svh"

module jdr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_direction_event
);

  // reset empties the result register
  `JDR_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "out_valid high after reset")

  // only the five direction codes leave the block
  `JDR_ASSERT(a_event_range, out_valid |-> (out_direction_event <= 3'd4), "bad direction code")

  // a stalled word holds
  `JDR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_direction_event), "stalled word changed")

  // the input side only backs up behind a full result register
  `JDR_ASSERT(a_ready_cause, !in_ready |-> out_valid, "input stalled with empty output")

endmodule

bind joystick_direction_repeat jdr_checker u_jdr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_direction_event (out_direction_event)
);
